### rtl/core/xclr_pkg.sv
// Shared constants, types and helper functions for the XOR checksummed line receiver.
`timescale 1ns / 1ps

package xclr_pkg;

    // Default maximum line length in stored bytes
    localparam int unsigned MaxLineDefault = 128;

    // Field widths
    localparam int unsigned ByteW    = 8;
    localparam int unsigned VerdictW = 2;
    localparam int unsigned PlenW    = 7;
    localparam int unsigned TailW    = 7;
    localparam int unsigned PhaseW   = 2;

    // Character codes
    localparam logic [ByteW-1:0] CharStar  = 8'h2A;
    localparam logic [ByteW-1:0] CharLf    = 8'h0A;
    localparam logic [ByteW-1:0] CharCr    = 8'h0D;
    localparam logic [ByteW-1:0] CharSpace = 8'h20;
    localparam logic [ByteW-1:0] CharTab   = 8'h09;
    localparam logic [ByteW-1:0] CharVt    = 8'h0B;
    localparam logic [ByteW-1:0] CharFf    = 8'h0C;

    // Verdict codes
    localparam logic [VerdictW-1:0] VerdictOk       = 2'd0;
    localparam logic [VerdictW-1:0] VerdictNoStar   = 2'd1;
    localparam logic [VerdictW-1:0] VerdictMismatch = 2'd2;
    localparam logic [VerdictW-1:0] VerdictEmpty    = 2'd3;

    // Hex parser phases
    localparam logic [PhaseW-1:0] PhaseSkip = 2'd0;
    localparam logic [PhaseW-1:0] PhaseDig  = 2'd1;
    localparam logic [PhaseW-1:0] PhaseStop = 2'd2;

    // Saturation limit of the tail counter
    localparam logic [TailW-1:0] TailMax = {TailW{1'b1}};

    // One line verdict as handed from the line processor to the output stage
    typedef struct packed {
        logic                emit;
        logic [VerdictW-1:0] verdict;
        logic [PlenW-1:0]    payload_length;
        logic [ByteW-1:0]    computed_checksum;
        logic [ByteW-1:0]    received_checksum;
    } result_t;

    // Bit 4: byte is a hex digit; bits 3:0: its value
    function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [ByteW-1:0] b);
        return (b == CharSpace) || (b == CharTab) || (b == CharVt) || (b == CharFf);
    endfunction

endpackage

### rtl/core/xclr_line_proc.sv
// Per-line state registers and the single-byte update and verdict logic.
`timescale 1ns / 1ps

module xclr_line_proc #(
    parameter int unsigned MAX_LINE = xclr_pkg::MaxLineDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [xclr_pkg::ByteW-1:0]    data,
    output xclr_pkg::result_t             result
);

    localparam int unsigned LcW = $clog2(MAX_LINE + 1);
    localparam logic [LcW-1:0] LineLimit = LcW'(MAX_LINE);

    logic [LcW-1:0]                 line_count_reg, line_count_next;
    logic [xclr_pkg::ByteW-1:0]     running_xor_reg, running_xor_next;
    logic [xclr_pkg::ByteW-1:0]     payload_xor_reg, payload_xor_next;
    logic                           star_seen_reg, star_seen_next;
    logic [LcW-1:0]                 star_pos_reg, star_pos_next;
    logic [xclr_pkg::TailW-1:0]     tail_count_reg, tail_count_next;
    logic [xclr_pkg::ByteW-1:0]     hex_acc_reg, hex_acc_next;
    logic [xclr_pkg::PhaseW-1:0]    hex_phase_reg, hex_phase_next;

    logic [4:0] digit;

    assign digit = xclr_pkg::hex_digit(data);

    always_comb
    begin
        line_count_next  = line_count_reg;
        running_xor_next = running_xor_reg;
        payload_xor_next = payload_xor_reg;
        star_seen_next   = star_seen_reg;
        star_pos_next    = star_pos_reg;
        tail_count_next  = tail_count_reg;
        hex_acc_next     = hex_acc_reg;
        hex_phase_next   = hex_phase_reg;
        result           = '0;

        if (data == xclr_pkg::CharCr)
        begin
            // ignored entirely
        end
        else if (data == xclr_pkg::CharLf || line_count_reg >= LineLimit)
        begin
            if (data == xclr_pkg::CharLf && line_count_reg != '0)
            begin
                result.emit = 1'b1;
                if (star_seen_reg)
                begin
                    result.payload_length    = xclr_pkg::PlenW'(star_pos_reg);
                    result.computed_checksum = payload_xor_reg;
                    result.received_checksum = hex_acc_reg;
                end
                if (!star_seen_reg || tail_count_reg < xclr_pkg::TailW'(2))
                begin
                    result.verdict = xclr_pkg::VerdictNoStar;
                end
                else if (star_pos_reg == '0)
                begin
                    result.verdict = xclr_pkg::VerdictEmpty;
                end
                else if (hex_acc_reg != payload_xor_reg)
                begin
                    result.verdict = xclr_pkg::VerdictMismatch;
                end
                else
                begin
                    result.verdict = xclr_pkg::VerdictOk;
                end
            end
            // newline ends the line; overflow drops the byte and the line
            line_count_next  = '0;
            running_xor_next = '0;
            payload_xor_next = '0;
            star_seen_next   = 1'b0;
            star_pos_next    = '0;
            tail_count_next  = '0;
            hex_acc_next     = '0;
            hex_phase_next   = xclr_pkg::PhaseSkip;
        end
        else
        begin
            if (data == xclr_pkg::CharStar)
            begin
                // last star wins
                payload_xor_next = running_xor_reg;
                star_pos_next    = line_count_reg;
                star_seen_next   = 1'b1;
                tail_count_next  = '0;
                hex_acc_next     = '0;
                hex_phase_next   = xclr_pkg::PhaseSkip;
            end
            else if (star_seen_reg)
            begin
                if (tail_count_reg != xclr_pkg::TailMax)
                begin
                    tail_count_next = tail_count_reg + 1'b1;
                end
                case (hex_phase_reg)
                    xclr_pkg::PhaseSkip:
                    begin
                        if (digit[4])
                        begin
                            hex_acc_next   = {4'd0, digit[3:0]};
                            hex_phase_next = xclr_pkg::PhaseDig;
                        end
                        else if (!xclr_pkg::is_blank(data))
                        begin
                            hex_phase_next = xclr_pkg::PhaseStop;
                        end
                    end
                    xclr_pkg::PhaseDig:
                    begin
                        if (digit[4])
                        begin
                            hex_acc_next = {hex_acc_reg[3:0], digit[3:0]};
                        end
                        else
                        begin
                            hex_phase_next = xclr_pkg::PhaseStop;
                        end
                    end
                    default:
                    begin
                        // stopped: hold
                    end
                endcase
            end
            running_xor_next = running_xor_reg ^ data;
            line_count_next  = line_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg  <= '0;
            running_xor_reg <= '0;
            payload_xor_reg <= '0;
            star_seen_reg   <= 1'b0;
            star_pos_reg    <= '0;
            tail_count_reg  <= '0;
            hex_acc_reg     <= '0;
            hex_phase_reg   <= xclr_pkg::PhaseSkip;
        end
        else if (step)
        begin
            line_count_reg  <= line_count_next;
            running_xor_reg <= running_xor_next;
            payload_xor_reg <= payload_xor_next;
            star_seen_reg   <= star_seen_next;
            star_pos_reg    <= star_pos_next;
            tail_count_reg  <= tail_count_next;
            hex_acc_reg     <= hex_acc_next;
            hex_phase_reg   <= hex_phase_next;
        end
    end

endmodule

### rtl/core/xor_checksummed_line_receiver_core.sv
// Top level of the XOR checksummed line receiver: input register, line processor, result register.
`timescale 1ns / 1ps

// Takes one received byte per transaction on the input channel and gives one
// verdict transaction per newline that ends a non-empty line. A line has the
// form "<payload>*<hex>"; carriage returns are ignored, the XOR of the bytes
// before the last star is compared with the hex value after it (leading
// blanks skipped, low eight bits kept). A byte arriving when the line already
// holds MAX_LINE bytes clears the line and is dropped. Timing: a byte is
// captured in an input register, processed by the line state logic as soon
// as the result register is free or being drained, and a verdict is then
// registered in the result register, which drives out_valid. One byte per
// cycle is taken in steady state; the input stalls only while a verdict
// sits unclaimed in the result register and the input register is full,
// so the output handshake alone sets the rate. There are no memories and
// no start-up clearing pass: the block is ready as soon as reset is released.

module xor_checksummed_line_receiver_core #(
    parameter int unsigned MAX_LINE = xclr_pkg::MaxLineDefault
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [xclr_pkg::ByteW-1:0]       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [xclr_pkg::VerdictW-1:0]    verdict,
    output logic [xclr_pkg::PlenW-1:0]       payload_length,
    output logic [xclr_pkg::ByteW-1:0]       computed_checksum,
    output logic [xclr_pkg::ByteW-1:0]       received_checksum
);

    // Input register
    logic                          in_valid_reg, in_valid_next;
    logic [xclr_pkg::ByteW-1:0]    byte_reg;

    // Result register
    logic                          out_valid_reg, out_valid_next;
    xclr_pkg::result_t             res_reg;

    xclr_pkg::result_t             res;
    logic                          advance;

    // The held byte moves on whenever the result register is free or being
    // drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    xclr_line_proc #(
        .MAX_LINE (MAX_LINE)
    ) u_line_proc (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .data   (byte_reg),
        .result (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        if (advance && res.emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign verdict           = res_reg.verdict;
    assign payload_length    = res_reg.payload_length;
    assign computed_checksum = res_reg.computed_checksum;
    assign received_checksum = res_reg.received_checksum;

endmodule

### rtl/core/xclr_checker.sv
// Port-level assertions for the XOR checksummed line receiver, bound to the top level.
`timescale 1ns / 1ps

module xclr_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [xclr_pkg::ByteW-1:0]       rx_byte,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [xclr_pkg::VerdictW-1:0]    verdict,
    input  logic [xclr_pkg::PlenW-1:0]       payload_length,
    input  logic [xclr_pkg::ByteW-1:0]       computed_checksum,
    input  logic [xclr_pkg::ByteW-1:0]       received_checksum
);

    // A stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict)
            && $stable(payload_length) && $stable(computed_checksum)
            && $stable(received_checksum))
        else $error("verdict changed while stalled");

    // A fresh verdict follows an accepted newline via the input and result registers
    a_out_from_lf: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && rx_byte == xclr_pkg::CharLf, 2))
        else $error("verdict without a newline");

    a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == xclr_pkg::VerdictOk |-> computed_checksum == received_checksum)
        else $error("ok verdict with differing checksums");

    a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == xclr_pkg::VerdictMismatch
            |-> computed_checksum != received_checksum)
        else $error("mismatch verdict with equal checksums");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == xclr_pkg::VerdictEmpty
            |-> payload_length == '0 && computed_checksum == '0)
        else $error("empty payload verdict with payload data");

endmodule

bind xor_checksummed_line_receiver_core xclr_checker u_xclr_checker (.*);
